>>> src/atcd_pkg.sv
// shared constants, codes and helpers of the ascii tuning command decoder
// no dependencies

package atcd_pkg;

	localparam int LINE_CHARS_DEF   = 31;
	localparam int FRAC_DIGITS_DEF  = 5;
	localparam int DEFAULT_FAST_DEF = 100;
	localparam int DEFAULT_SLOW_DEF = 70;
	localparam int DEFAULT_MIN_DEF  = 40;

	localparam int CHAR_W  = 8;
	localparam int SPEED_W = 15;
	localparam int GAIN_W  = 32;
	localparam int ACT_W   = 3;
	localparam int SEL_W   = 3;
	localparam int MASK_W  = 2;
	localparam int OUT_W   = 88;

	localparam int IPART_W = 16;
	localparam int FNUM_W  = 20;
	localparam int K_W     = 3;
	localparam int SCNT_W  = 10;
	localparam int DEN_W   = 21;
	localparam int NUM_W   = 37;

	localparam logic [9:0]         SCALE_MAX  = 10'd200;
	localparam logic [9:0]         SCNT_SAT   = 10'd1000;
	localparam logic [IPART_W-1:0] IPART_SAT  = 16'd32768;
	localparam logic [SPEED_W-1:0] SPEED_MAX  = 15'h7FFF;
	localparam logic [GAIN_W-1:0]  GAIN_MAX   = 32'h7FFF_FFFF;

	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_QUERY = 8'h3F;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UB    = 8'h42;
	localparam logic [CHAR_W-1:0] CH_UD    = 8'h44;
	localparam logic [CHAR_W-1:0] CH_UH    = 8'h48;
	localparam logic [CHAR_W-1:0] CH_UI    = 8'h49;
	localparam logic [CHAR_W-1:0] CH_UK    = 8'h4B;
	localparam logic [CHAR_W-1:0] CH_UP    = 8'h50;
	localparam logic [CHAR_W-1:0] CH_US    = 8'h53;
	localparam logic [CHAR_W-1:0] CH_UT    = 8'h54;
	localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LH    = 8'h68;

	typedef logic [ACT_W-1:0] action_t;
	localparam action_t ACT_STATUS  = 3'd0;
	localparam action_t ACT_HELP    = 3'd1;
	localparam action_t ACT_GAIN    = 3'd2;
	localparam action_t ACT_SCALED  = 3'd3;
	localparam action_t ACT_IGNORED = 3'd4;
	localparam action_t ACT_UNKNOWN = 3'd5;

	typedef logic [SEL_W-1:0] gain_sel_t;
	localparam gain_sel_t SEL_PID_P   = 3'd0;
	localparam gain_sel_t SEL_PID_I   = 3'd1;
	localparam gain_sel_t SEL_PID_D   = 3'd2;
	localparam gain_sel_t SEL_STEER_P = 3'd3;
	localparam gain_sel_t SEL_STEER_D = 3'd4;

	localparam logic [MASK_W-1:0] MASK_NONE = 2'd0;
	localparam logic [MASK_W-1:0] MASK_A    = 2'd1;
	localparam logic [MASK_W-1:0] MASK_B    = 2'd2;
	localparam logic [MASK_W-1:0] MASK_AB   = 2'd3;

	// ten to the power k, k up to six
	function automatic logic [FNUM_W-1:0] pow10(input logic [K_W-1:0] k);
		logic [FNUM_W-1:0] r;
		case (k)
			3'd0:    r = 20'd1;
			3'd1:    r = 20'd10;
			3'd2:    r = 20'd100;
			3'd3:    r = 20'd1000;
			3'd4:    r = 20'd10000;
			3'd5:    r = 20'd100000;
			3'd6:    r = 20'd1000000;
			default: r = 20'd1;
		endcase
		return r;
	endfunction

endpackage

>>> src/ascii_tuning_command_decoder.sv
// ascii tuning command decoder: line store in ram, sequencer that walks the line,
// shared bit-serial divider for gain fraction rounding and speed rescaling
// depends on atcd_pkg and atcd_ram
//
// channel | dir | width | contents
// s_*     | in  | 8     | rx_byte
// m_*     | out | 88    | action, gain_select, motor_mask, gain_value, fast, slow, min
//
// a character byte is taken while the decoder is idle; a line end starts a decode that reads
// the stored line from the ram one character at a time, an address state then a data state each
// status, help and unknown lines load the result after the first two characters, a gain
// after a divider pass over 37 quotient bits, a speed scale after two multiply
// and divide passes; bad values stop early
// s_tready is low from the end of a nonempty line until the result is loaded into the output
// register, which waits while an earlier result is still held there
// reset clears the line length and loads the default speeds

module ascii_tuning_command_decoder
	import atcd_pkg::*;
#(
	parameter int LINE_CHARS   = LINE_CHARS_DEF,
	parameter int FRAC_DIGITS  = FRAC_DIGITS_DEF,
	parameter int DEFAULT_FAST = DEFAULT_FAST_DEF,
	parameter int DEFAULT_SLOW = DEFAULT_SLOW_DEF,
	parameter int DEFAULT_MIN  = DEFAULT_MIN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,  // rx_byte
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // action, gain_select, motor_mask, gain_value,
	                                   // speed_fast_out, speed_slow_out, speed_min_out
);

	localparam int AW = $clog2(LINE_CHARS);
	localparam int PW = $clog2(LINE_CHARS + 1);
	localparam int CW = $clog2(NUM_W + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_ADDR, ST_DATA, ST_MUL, ST_DIV, ST_DONE} state_t;
	typedef enum logic [2:0] {PH_C0, PH_C1, PH_GFIRST, PH_GINT, PH_GFRAC, PH_SCALE} phase_t;
	typedef enum logic [1:0] {DV_FRAC, DV_SLOW, DV_MIN} div_t;

	state_t               st_q;
	phase_t               ph_q;
	div_t                 dv_q;
	logic [PW-1:0]        len_q;
	logic [PW-1:0]        pos_q;
	logic [CHAR_W-1:0]    c0_q;
	action_t              act_q;
	gain_sel_t            sel_q;
	logic [MASK_W-1:0]    mask_q;
	logic [GAIN_W-1:0]    val_q;
	logic                 neg_q;
	logic [IPART_W-1:0]   ipart_q;
	logic [FNUM_W-1:0]    fnum_q;
	logic [K_W-1:0]       k_q;
	logic [SCNT_W-1:0]    n_q;
	logic [NUM_W-1:0]     num_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_q;
	logic [CW-1:0]        cnt_q;
	logic [SPEED_W-1:0]   fast_q;
	logic [SPEED_W-1:0]   slow_q;
	logic [SPEED_W-1:0]   min_q;
	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     m_tdata_q;

	logic                 in_acc;
	logic                 line_end;
	logic                 ram_we;
	logic [CHAR_W-1:0]    rdata;
	logic [CHAR_W-1:0]    ch;
	logic                 is_dig;
	logic [3:0]           dig;
	logic [19:0]          ipart_x10;
	logic [IPART_W-1:0]   ipart_nx;
	logic [23:0]          fnum_x10;
	logic [13:0]          n_x10;
	logic [SCNT_W-1:0]    n_nx;
	logic                 pid_c0;
	logic                 c1_upper;
	logic [FNUM_W-1:0]    fden;
	logic [NUM_W-1:0]     frac_num;
	logic [DEN_W:0]       rem_sh;
	logic                 ge;
	logic [DEN_W:0]       rem_sub;
	logic [SPEED_W-1:0]   old_spd;
	logic [22:0]          prod;
	logic [SPEED_W-1:0]   quo_sat;
	logic [32:0]          mag;
	logic [GAIN_W-1:0]    mag_sat;
	gain_sel_t            pid_sel;
	logic                 out_free;

	assign in_acc   = s_tvalid & s_tready;
	assign line_end = (s_tdata == CH_CR) || (s_tdata == CH_LF);
	assign ram_we   = in_acc && !line_end && (len_q < PW'(LINE_CHARS));
	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	atcd_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(LINE_CHARS)
	) u_line (
		.clk  (clk),
		.we   (ram_we),
		.waddr(len_q[AW-1:0]),
		.wdata(s_tdata),
		.raddr(pos_q[AW-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		ch        = (pos_q < len_q) ? rdata : '0;
		is_dig    = (ch >= CH_ZERO) && (ch <= CH_NINE);
		dig       = ch[3:0];
		ipart_x10 = {1'b0, ipart_q, 3'b000} + {3'b000, ipart_q, 1'b0} + 20'(dig);
		ipart_nx  = (ipart_x10 > 20'(IPART_SAT)) ? IPART_SAT : ipart_x10[IPART_W-1:0];
		fnum_x10  = {1'b0, fnum_q, 3'b000} + {3'b000, fnum_q, 1'b0} + 24'(dig);
		n_x10     = {1'b0, n_q, 3'b000} + {3'b000, n_q, 1'b0} + 14'(dig);
		n_nx      = (n_x10 > 14'(SCNT_SAT)) ? SCNT_SAT : n_x10[SCNT_W-1:0];
		pid_c0    = (c0_q == CH_UP) || (c0_q == CH_UI) || (c0_q == CH_UD);
		c1_upper  = (ch >= CH_UA) && (ch <= CH_UZ);
		pid_sel   = (c0_q == CH_UP) ? SEL_PID_P : ((c0_q == CH_UI) ? SEL_PID_I : SEL_PID_D);
		fden      = pow10(k_q);
		frac_num  = {fnum_q, 17'b0} + NUM_W'(fden);
		rem_sh    = {rem_q, num_q[NUM_W-1]};
		ge        = rem_sh >= {1'b0, den_q};
		rem_sub   = rem_sh - {1'b0, den_q};
		old_spd   = (dv_q == DV_SLOW) ? slow_q : min_q;
		prod      = 23'(old_spd) * 23'(n_q[7:0]);
		quo_sat   = (|num_q[NUM_W-1:SPEED_W]) ? SPEED_MAX : num_q[SPEED_W-1:0];
		mag       = {1'b0, ipart_q, 16'b0} + 33'(num_q[16:0]);
		mag_sat   = (mag[32] || mag[31]) ? GAIN_MAX : mag[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			ph_q       <= PH_C0;
			dv_q       <= DV_FRAC;
			len_q      <= '0;
			pos_q      <= '0;
			c0_q       <= '0;
			act_q      <= ACT_STATUS;
			sel_q      <= SEL_PID_P;
			mask_q     <= MASK_NONE;
			val_q      <= '0;
			neg_q      <= 1'b0;
			ipart_q    <= '0;
			fnum_q     <= '0;
			k_q        <= '0;
			n_q        <= '0;
			num_q      <= '0;
			den_q      <= '0;
			rem_q      <= '0;
			cnt_q      <= '0;
			fast_q     <= SPEED_W'(DEFAULT_FAST);
			slow_q     <= SPEED_W'(DEFAULT_SLOW);
			min_q      <= SPEED_W'(DEFAULT_MIN);
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (ram_we) begin
						len_q <= len_q + PW'(1);
					end
					if (in_acc && line_end && (len_q != '0)) begin
						pos_q <= '0;
						ph_q  <= PH_C0;
						st_q  <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					st_q <= ST_DATA;
				end
				ST_DATA: begin
					st_q <= ST_ADDR;
					case (ph_q)
						PH_C0: begin
							c0_q  <= ch;
							pos_q <= PW'(1);
							ph_q  <= PH_C1;
						end
						PH_C1: begin
							neg_q   <= 1'b0;
							ipart_q <= '0;
							fnum_q  <= '0;
							k_q     <= '0;
							n_q     <= '0;
							ph_q    <= PH_GFIRST;
							if ((c0_q == CH_QUERY) || ((c0_q == CH_US) && (ch == CH_UT))) begin
								act_q <= ACT_STATUS;
								st_q  <= ST_DONE;
							end else if ((c0_q == CH_UH) || (c0_q == CH_LH)) begin
								act_q <= ACT_HELP;
								st_q  <= ST_DONE;
							end else if (pid_c0 && !c1_upper) begin
								sel_q  <= pid_sel;
								mask_q <= MASK_AB;
								pos_q  <= PW'(1);
							end else if (pid_c0 && ((ch == CH_UA) || (ch == CH_UB))) begin
								sel_q  <= pid_sel;
								mask_q <= (ch == CH_UA) ? MASK_A : MASK_B;
								pos_q  <= PW'(2);
							end else if (c0_q == CH_US) begin
								pos_q <= PW'(1);
								ph_q  <= PH_SCALE;
							end else if ((c0_q == CH_UK) && ((ch == CH_UP) || (ch == CH_UD))) begin
								sel_q  <= (ch == CH_UP) ? SEL_STEER_P : SEL_STEER_D;
								mask_q <= MASK_NONE;
								pos_q  <= PW'(2);
							end else begin
								act_q <= ACT_UNKNOWN;
								st_q  <= ST_DONE;
							end
						end
						PH_GFIRST: begin
							ph_q <= PH_GINT;
							if (ch == '0) begin
								act_q <= ACT_IGNORED;
								st_q  <= ST_DONE;
							end else if (ch == CH_MINUS) begin
								neg_q <= 1'b1;
								pos_q <= pos_q + PW'(1);
							end else if (ch == CH_PLUS) begin
								pos_q <= pos_q + PW'(1);
							end
						end
						PH_GINT, PH_GFRAC: begin
							if (is_dig) begin
								pos_q <= pos_q + PW'(1);
								if (ph_q == PH_GINT) begin
									ipart_q <= ipart_nx;
								end else if (k_q < K_W'(FRAC_DIGITS)) begin
									fnum_q <= fnum_x10[FNUM_W-1:0];
									k_q    <= k_q + K_W'(1);
								end
							end else if ((ph_q == PH_GINT) && (ch == CH_DOT)) begin
								pos_q <= pos_q + PW'(1);
								ph_q  <= PH_GFRAC;
							end else begin
								num_q <= frac_num;
								den_q <= {fden, 1'b0};
								rem_q <= '0;
								cnt_q <= CW'(NUM_W);
								dv_q  <= DV_FRAC;
								st_q  <= ST_DIV;
							end
						end
						PH_SCALE: begin
							if (is_dig) begin
								n_q   <= n_nx;
								pos_q <= pos_q + PW'(1);
							end else if ((n_q != '0) && (n_q <= SCALE_MAX) && (fast_q != '0)) begin
								dv_q <= DV_SLOW;
								st_q <= ST_MUL;
							end else begin
								act_q <= ACT_IGNORED;
								st_q  <= ST_DONE;
							end
						end
						default: begin
							st_q <= ST_IDLE;
						end
					endcase
				end
				ST_MUL: begin
					num_q <= NUM_W'({prod, 1'b0}) + NUM_W'(fast_q);
					den_q <= DEN_W'({fast_q, 1'b0});
					rem_q <= '0;
					cnt_q <= CW'(NUM_W);
					st_q  <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q != '0) begin
						rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
						num_q <= {num_q[NUM_W-2:0], ge};
						cnt_q <= cnt_q - CW'(1);
					end else begin
						case (dv_q)
							DV_FRAC: begin
								val_q <= neg_q ? (GAIN_W'(0) - mag_sat) : mag_sat;
								act_q <= ACT_GAIN;
								st_q  <= ST_DONE;
							end
							DV_SLOW: begin
								slow_q <= quo_sat;
								dv_q   <= DV_MIN;
								st_q   <= ST_MUL;
							end
							default: begin
								min_q  <= quo_sat;
								fast_q <= SPEED_W'(n_q);
								act_q  <= ACT_SCALED;
								st_q   <= ST_DONE;
							end
						endcase
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (act_q == ACT_GAIN) begin
							m_tdata_q <= {3'b000, min_q, slow_q, fast_q, val_q, mask_q, sel_q,
								act_q};
						end else begin
							m_tdata_q <= {3'b000, min_q, slow_q, fast_q, GAIN_W'(0), MASK_NONE,
								SEL_PID_P, act_q};
						end
						len_q <= '0;
						st_q  <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= PW'(LINE_CHARS))
		else $error("line length beyond store depth");

	a_gain_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] != ACT_GAIN) |-> (m_tdata[39:3] == '0))
		else $error("gain fields set on a non-gain transaction");

	a_scaled_fast: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == ACT_SCALED) |->
			(m_tdata[54:40] != '0) && (m_tdata[54:40] <= 15'd200))
		else $error("scaled speed out of range");

	a_busy_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && line_end && (len_q != '0) |=> !s_tready)
		else $error("line end did not start a decode");

endmodule

>>> src/atcd_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module atcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 31
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
